// ===== sv/eabt_pkg.sv =====
package eabt_pkg;

  // Field widths fixed by the request and result format.
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned TIME_W   = 40;
  localparam int unsigned EXPIRY_W = 41;
  localparam int unsigned BTIME_W  = 20;
  localparam int unsigned LFSR_W   = 16;

  // Configuration port geometry.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_BLOCK_TIME_ADDR = 3'd0;

  localparam logic [BTIME_W-1:0] BLOCK_TIME_RESET = 20'd3000;

  // Victim selection LFSR (Galois form).
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  // Request operation codes; the fourth code is a no-op.
  typedef enum logic [1:0] {
    OP_BAD   = 2'd0,
    OP_GOOD  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic                valid;
    logic                is_v6;
    logic [KEY_W-1:0]    key;
    logic [EXPIRY_W-1:0] expiry;
  } entry_t;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] r;
    r = s >> 1;
    if (s[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

endpackage

// ===== sv/expiring_address_block_table_unit.sv =====
// Channel    Direction  Handshake            Payload
// request    in         req_valid/req_ready  op, addr_is_v6, addr_prefix, now_time
// result     out        rsp_valid/rsp_ready  throttled, evicted_live, entry_found
// config     in         APB (psel/penable)   block_time at byte address 0
//
// A request walks the entry memory once, one entry per cycle through its single read port.
// After acceptance a request passes the scan, a decision step (S_POST) and the result
// register; a bad attempt adds the write, an eviction also the LFSR remainder and the clear.
// After reset a clearing pass over every entry empties the memory; requests wait,
// configuration writes are taken. A stalled result holds in the output register; the next
// request is taken while it waits, and its walk holds in its last step until it is free.
module expiring_address_block_table_unit #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [1:0]                          op,
  input  logic                                addr_is_v6,
  input  logic [eabt_pkg::KEY_W-1:0]          addr_prefix,
  input  logic [eabt_pkg::TIME_W-1:0]         now_time,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic                                throttled,
  output logic                                evicted_live,
  output logic                                entry_found,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [eabt_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [eabt_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [eabt_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import eabt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  // Reciprocal of the depth, exact for every LFSR value.
  localparam int unsigned       RCP_SH  = LFSR_W + IDX_W;
  localparam logic [LFSR_W:0]   RCP     = (LFSR_W + 1)'(((64'd1 << RCP_SH) +
                                          64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));
  localparam logic [LFSR_W-1:0] DEPTH_L = LFSR_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_POST,
    S_MOD,
    S_EVICT,
    S_WRITE,
    S_DONE
  } state_t;

  state_t state;

  // Configuration register and APB access.
  logic [BTIME_W-1:0] block_time;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_BLOCK_TIME_ADDR);
  assign prdata    = (paddr == REG_BLOCK_TIME_ADDR) ?
                     APB_DATA_W'(block_time) : '0;

  // Latched request.
  op_t                op_r;
  logic               v6_r;
  logic [KEY_W-1:0]   key_r;
  logic [TIME_W-1:0]  now_r;

  // Scan bookkeeping.
  logic [IDX_W-1:0]   scan_idx;
  logic               issuing;
  logic               proc_vld;
  logic [IDX_W-1:0]   proc_idx;
  logic               purge_mode;
  logic [CNT_W-1:0]   count;
  logic               found;
  logic               match_hit;
  logic [IDX_W-1:0]   match_idx;
  logic               live_r;
  logic               free_hit;
  logic [IDX_W-1:0]   free_idx;
  logic               evicted;

  // Victim selection.
  logic                  [LFSR_W-1:0] lfsr;
  logic                  mod_step;
  logic [2*LFSR_W:0]     mod_prod;
  logic [LFSR_W-1:0]     mod_quot;
  logic [2*LFSR_W-1:0]   mod_qmul;
  logic [LFSR_W-1:0]     mod_rem;
  logic [IDX_W-1:0]      rem;

  // Entry memory ports.
  entry_t             mem [TABLE_DEPTH];
  entry_t             rd_data;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;

  // Per-entry tests on the word read back during the scan.
  logic               e_hit;
  logic               e_expired;
  logic               e_purge;
  logic               e_free;
  logic [EXPIRY_W-1:0] new_expiry;
  logic [IDX_W-1:0]   write_slot;

  assign e_hit      = rd_data.valid && (rd_data.is_v6 == v6_r) && (rd_data.key == key_r);
  assign e_expired  = rd_data.expiry <= {1'b0, now_r};
  assign e_purge    = purge_mode && rd_data.valid && e_expired;
  assign e_free     = !rd_data.valid || e_purge;
  assign new_expiry = {1'b0, now_r} + EXPIRY_W'(block_time);
  assign write_slot = match_hit ? match_idx : free_idx;

  // Remainder from the registered reciprocal product.
  assign mod_quot   = LFSR_W'(mod_prod >> RCP_SH);
  assign mod_qmul   = (2 * LFSR_W)'(mod_quot) * (2 * LFSR_W)'(DEPTH_L);
  assign mod_rem    = lfsr - mod_qmul[LFSR_W-1:0];

  assign req_ready  = (state == S_IDLE);

  // Memory write selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_idx;
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_SCAN: begin
        if (proc_vld && e_purge) begin
          mem_we          = 1'b1;
          mem_waddr       = proc_idx;
          mem_wdata       = rd_data;
          mem_wdata.valid = 1'b0;
        end
      end
      S_POST: begin
        if (op_r == OP_GOOD && match_hit) begin
          mem_we    = 1'b1;
          mem_waddr = match_idx;
        end
      end
      S_EVICT: begin
        mem_we    = 1'b1;
        mem_waddr = rem;
      end
      S_WRITE: begin
        mem_we           = 1'b1;
        mem_waddr        = write_slot;
        mem_wdata.valid  = 1'b1;
        mem_wdata.is_v6  = v6_r;
        mem_wdata.key    = key_r;
        mem_wdata.expiry = new_expiry;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[scan_idx];
  end

  // Sequencer, counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      block_time   <= BLOCK_TIME_RESET;
      scan_idx     <= '0;
      issuing      <= 1'b0;
      proc_vld     <= 1'b0;
      count        <= '0;
      lfsr         <= LFSR_SEED;
      rsp_valid    <= 1'b0;
      throttled    <= 1'b0;
      evicted_live <= 1'b0;
      entry_found  <= 1'b0;
    end else begin
      if (cfg_write) begin
        block_time <= pwdata[BTIME_W-1:0];
      end

      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        // Empty the entry memory once after reset.
        S_CLEAR: begin
          if (scan_idx == LAST_IDX) begin
            scan_idx <= '0;
            state    <= S_IDLE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end

        // Take a request and start the walk at entry zero.
        S_IDLE: begin
          if (req_valid) begin
            op_r       <= op_t'(op);
            v6_r       <= addr_is_v6;
            key_r      <= addr_prefix;
            now_r      <= now_time;
            scan_idx   <= '0;
            issuing    <= 1'b1;
            proc_vld   <= 1'b0;
            purge_mode <= (op_t'(op) == OP_BAD) && (count == FULL_COUNT);
            found      <= 1'b0;
            match_hit  <= 1'b0;
            live_r     <= 1'b0;
            free_hit   <= 1'b0;
            evicted    <= 1'b0;
            state      <= S_SCAN;
          end
        end

        // Find key and lowest hole; a bad attempt to a full table purges expired entries.
        S_SCAN: begin
          proc_vld <= issuing;
          proc_idx <= scan_idx;
          if (issuing) begin
            if (scan_idx == LAST_IDX) begin
              issuing <= 1'b0;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
          if (proc_vld) begin
            if (e_hit) begin
              found  <= 1'b1;
              live_r <= !e_expired;
              if (!e_purge) begin
                match_hit <= 1'b1;
                match_idx <= proc_idx;
              end
            end
            if (e_free && !free_hit) begin
              free_hit <= 1'b1;
              free_idx <= proc_idx;
            end
            if (e_purge) begin
              count <= count - 1'b1;
            end
            if (proc_idx == LAST_IDX) begin
              state <= S_POST;
            end
          end
        end

        // Decide what the operation still has to change.
        S_POST: begin
          scan_idx <= '0;
          unique case (op_r)
            OP_BAD: begin
              if (count == FULL_COUNT) begin
                lfsr     <= lfsr_next(lfsr);
                mod_step <= 1'b0;
                state    <= S_MOD;
              end else begin
                state <= S_WRITE;
              end
            end
            OP_GOOD: begin
              if (match_hit) begin
                count <= count - 1'b1;
              end
              state <= S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end

        // Victim index: LFSR value modulo the depth by reciprocal multiplication.
        S_MOD: begin
          if (!mod_step) begin
            mod_prod <= (2 * LFSR_W + 1)'(lfsr) * (2 * LFSR_W + 1)'(RCP);
            mod_step <= 1'b1;
          end else begin
            rem   <= mod_rem[IDX_W-1:0];
            state <= S_EVICT;
          end
        end

        // Drop the victim; the new entry takes its slot unless the key survives elsewhere.
        S_EVICT: begin
          evicted  <= 1'b1;
          count    <= count - 1'b1;
          free_idx <= rem;
          if (match_hit && match_idx == rem) begin
            match_hit <= 1'b0;
          end
          state <= S_WRITE;
        end

        // Store the key with its new expiry.
        S_WRITE: begin
          if (!match_hit) begin
            count <= count + 1'b1;
          end
          state <= S_DONE;
        end

        // Hand the result to the output register once it is free.
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid    <= 1'b1;
            throttled    <= (op_r == OP_QUERY) && match_hit && live_r;
            evicted_live <= (op_r == OP_BAD) && evicted;
            entry_found  <= found &&
                            (op_r == OP_BAD || op_r == OP_GOOD || op_r == OP_QUERY);
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
